// ===== rtl/svt_pkg.sv =====
// Shared types, constants and helper functions for the sprite quad transform.
`timescale 1ns / 1ps

package svt_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int ROT_FRAC     = 30;
    localparam int WIDE_W       = 66;
    localparam int ROT_W        = 36;
    localparam int QPTR_W       = 2;
    localparam int QDEPTH       = 1 << QPTR_W;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [WIDE_W-1:0]   SAT_MAX     = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0]   SAT_MIN     = -66'sd2147483648;

    // bit k set: corner k sits on the +1 side of that axis, else on the 0 side
    localparam logic [3:0] CORNER_HI_X = 4'b0110;
    localparam logic [3:0] CORNER_HI_Y = 4'b1100;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_xy;

    typedef struct packed {
        logic signed [31:0] vx0;
        logic signed [31:0] vx1;
        logic signed [31:0] vy0;
        logic signed [31:0] vy1;
    } t_v4;

    typedef struct packed {
        logic signed [31:0] cs;
        logic signed [31:0] sn;
        t_v4                v;
        t_xy                pos;
    } t_fq;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
    function automatic logic signed [31:0] atan_turn(input int i);
        logic signed [31:0] r;
        case (i)
            0:       r = 32'sd536870912;
            1:       r = 32'sd316933406;
            2:       r = 32'sd167458907;
            3:       r = 32'sd85004756;
            4:       r = 32'sd42667331;
            5:       r = 32'sd21354465;
            6:       r = 32'sd10679838;
            7:       r = 32'sd5340245;
            8:       r = 32'sd2670163;
            9:       r = 32'sd1335087;
            10:      r = 32'sd667544;
            11:      r = 32'sd333772;
            12:      r = 32'sd166886;
            13:      r = 32'sd83443;
            14:      r = 32'sd41722;
            15:      r = 32'sd20861;
            16:      r = 32'sd10430;
            17:      r = 32'sd5215;
            18:      r = 32'sd2608;
            19:      r = 32'sd1304;
            20:      r = 32'sd652;
            21:      r = 32'sd326;
            22:      r = 32'sd163;
            23:      r = 32'sd81;
            24:      r = 32'sd41;
            25:      r = 32'sd20;
            26:      r = 32'sd10;
            27:      r = 32'sd5;
            28:      r = 32'sd3;
            29:      r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sprite_quad_vertex_transform.sv =====
// Sprite quad transform top: four rotated, scaled and translated corners per sprite.
// Path from input accept to o_valid: 31 front stages, the queue, then 3 back stages.
// Throughput: one sprite per cycle unless stalled, set by the 30-stage CORDIC and the per-stage multipliers.
// A 4-entry queue decouples front and back; an output stall fills it before o_stall rises.
// Synchronous active-low reset clears valid bits and queue pointers; no clearing pass.
`timescale 1ns / 1ps

module sprite_quad_vertex_transform #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_scale_x,
    input  logic signed [31:0]    i_scale_y,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  logic signed [31:0]    i_pivot_x,
    input  logic signed [31:0]    i_pivot_y,
    input  logic signed [31:0]    i_size_x,
    input  logic signed [31:0]    i_size_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_corner0_x,
    output logic signed [31:0]    o_corner0_y,
    output logic signed [31:0]    o_corner1_x,
    output logic signed [31:0]    o_corner1_y,
    output logic signed [31:0]    o_corner2_x,
    output logic signed [31:0]    o_corner2_y,
    output logic signed [31:0]    o_corner3_x,
    output logic signed [31:0]    o_corner3_y
);

    logic         w_wr;
    logic         w_full;
    logic         w_rd;
    logic         w_empty;
    svt_pkg::t_fq w_wdata;
    svt_pkg::t_fq w_rdata;
    svt_pkg::t_xy w_corner [4];

    svt_front #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_scale_x (i_scale_x),
        .i_scale_y (i_scale_y),
        .i_angle   (i_angle),
        .i_pivot_x (i_pivot_x),
        .i_pivot_y (i_pivot_y),
        .i_size_x  (i_size_x),
        .i_size_y  (i_size_y),
        .o_wr      (w_wr),
        .o_wdata   (w_wdata),
        .i_full    (w_full)
    );

    svt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wdata),
        .o_full  (w_full),
        .i_rd    (w_rd),
        .o_rdata (w_rdata),
        .o_empty (w_empty)
    );

    svt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .o_rd     (w_rd),
        .i_rdata  (w_rdata),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_corner (w_corner)
    );

    assign o_corner0_x = w_corner[0].x;
    assign o_corner0_y = w_corner[0].y;
    assign o_corner1_x = w_corner[1].x;
    assign o_corner1_y = w_corner[1].y;
    assign o_corner2_x = w_corner[2].x;
    assign o_corner2_y = w_corner[2].y;
    assign o_corner3_x = w_corner[3].x;
    assign o_corner3_y = w_corner[3].y;

endmodule

// ===== rtl/svt_front.sv =====
// Front pipeline: offset, scale and size per axis, and the CORDIC sine and cosine.
`timescale 1ns / 1ps

module svt_front #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [31:0]     i_pos_x,
    input  logic signed [31:0]     i_pos_y,
    input  logic signed [31:0]     i_scale_x,
    input  logic signed [31:0]     i_scale_y,
    input  logic [ANGLE_BITS-1:0]  i_angle,
    input  logic signed [31:0]     i_pivot_x,
    input  logic signed [31:0]     i_pivot_y,
    input  logic signed [31:0]     i_size_x,
    input  logic signed [31:0]     i_size_y,
    output logic                   o_wr,
    output svt_pkg::t_fq           o_wdata,
    input  logic                   i_full
);

    localparam int STEPS = svt_pkg::CORDIC_STEPS;
    localparam int CW    = svt_pkg::CORDIC_W;
    localparam int WW    = svt_pkg::WIDE_W;
    localparam logic signed [32:0] ONE  = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [WW-1:0] BIAS = 66'sd1 <<< (FRAC_BITS - 1);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic                 en;
    logic [STEPS:0]       r_vld;
    logic [31:0]          w_turn;

    logic signed [32:0]   r_ox [2];
    logic signed [32:0]   r_oy [2];
    logic signed [31:0]   r_scl_x;
    logic signed [31:0]   r_scl_y;
    logic signed [31:0]   r_siz_x [3];
    logic signed [31:0]   r_siz_y [3];
    logic signed [WW-1:0] r_px [2];
    logic signed [WW-1:0] r_py [2];
    logic signed [31:0]   r_sx [2];
    logic signed [31:0]   r_sy [2];
    logic signed [WW-1:0] r_qx [2];
    logic signed [WW-1:0] r_qy [2];
    svt_pkg::t_v4         r_v   [4:STEPS];
    svt_pkg::t_xy         r_pos [0:STEPS];

    logic signed [CW-1:0] r_cx [0:STEPS];
    logic signed [CW-1:0] r_cy [0:STEPS];
    logic signed [31:0]   r_cz [0:STEPS-1];
    logic [1:0]           r_cq [0:STEPS];

    logic signed [CW-1:0] w_cs;
    logic signed [CW-1:0] w_sn;

    assign en      = !(r_vld[STEPS] && i_full);
    assign o_stall = !en;
    assign o_wr    = r_vld[STEPS] && !i_full;
    assign w_turn  = {i_angle, {(32 - ANGLE_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox[0]    <= -(33'(i_pivot_x));
            r_ox[1]    <= ONE - 33'(i_pivot_x);
            r_oy[0]    <= -(33'(i_pivot_y));
            r_oy[1]    <= ONE - 33'(i_pivot_y);
            r_scl_x    <= i_scale_x;
            r_scl_y    <= i_scale_y;
            r_siz_x[0] <= i_size_x;
            r_siz_y[0] <= i_size_y;
            r_pos[0]   <= '{x: i_pos_x, y: i_pos_y};
            r_cx[0]    <= svt_pkg::CORDIC_GAIN;
            r_cy[0]    <= '0;
            r_cz[0]    <= signed'({2'b00, w_turn[29:0]});
            r_cq[0]    <= w_turn[31:30];

            r_siz_x[1] <= r_siz_x[0];
            r_siz_y[1] <= r_siz_y[0];
            r_siz_x[2] <= r_siz_x[1];
            r_siz_y[2] <= r_siz_y[1];
            for (int n = 0; n < 2; n++) begin
                r_px[n] <= WW'(r_ox[n]) * WW'(r_scl_x) + BIAS;
                r_py[n] <= WW'(r_oy[n]) * WW'(r_scl_y) + BIAS;
                r_sx[n] <= svt_pkg::sat32(r_px[n] >>> FRAC_BITS);
                r_sy[n] <= svt_pkg::sat32(r_py[n] >>> FRAC_BITS);
                r_qx[n] <= WW'(r_sx[n]) * WW'(r_siz_x[2]) + BIAS;
                r_qy[n] <= WW'(r_sy[n]) * WW'(r_siz_y[2]) + BIAS;
            end
            r_v[4].vx0 <= svt_pkg::sat32(r_qx[0] >>> FRAC_BITS);
            r_v[4].vx1 <= svt_pkg::sat32(r_qx[1] >>> FRAC_BITS);
            r_v[4].vy0 <= svt_pkg::sat32(r_qy[0] >>> FRAC_BITS);
            r_v[4].vy1 <= svt_pkg::sat32(r_qy[1] >>> FRAC_BITS);
            for (int j = 5; j <= STEPS; j++) begin
                r_v[j] <= r_v[j-1];
            end
            for (int j = 1; j <= STEPS; j++) begin
                r_pos[j] <= r_pos[j-1];
                r_cq[j]  <= r_cq[j-1];
            end
            for (int j = 1; j <= STEPS; j++) begin
                if (!r_cz[j-1][31]) begin
                    r_cx[j] <= r_cx[j-1] - (r_cy[j-1] >>> (j - 1));
                    r_cy[j] <= r_cy[j-1] + (r_cx[j-1] >>> (j - 1));
                end else begin
                    r_cx[j] <= r_cx[j-1] + (r_cy[j-1] >>> (j - 1));
                    r_cy[j] <= r_cy[j-1] - (r_cx[j-1] >>> (j - 1));
                end
            end
            for (int j = 1; j < STEPS; j++) begin
                if (!r_cz[j-1][31]) begin
                    r_cz[j] <= r_cz[j-1] - svt_pkg::atan_turn(j - 1);
                end else begin
                    r_cz[j] <= r_cz[j-1] + svt_pkg::atan_turn(j - 1);
                end
            end
        end
    end

    // fold the first-quadrant result back to the full turn
    always_comb begin
        case (r_cq[STEPS])
            QUAD_0: begin
                w_cs = r_cx[STEPS];
                w_sn = r_cy[STEPS];
            end
            QUAD_1: begin
                w_cs = -r_cy[STEPS];
                w_sn = r_cx[STEPS];
            end
            QUAD_2: begin
                w_cs = -r_cx[STEPS];
                w_sn = -r_cy[STEPS];
            end
            QUAD_3: begin
                w_cs = r_cy[STEPS];
                w_sn = -r_cx[STEPS];
            end
            default: begin
                w_cs = r_cx[STEPS];
                w_sn = r_cy[STEPS];
            end
        endcase
    end

    assign o_wdata.cs  = w_cs[31:0];
    assign o_wdata.sn  = w_sn[31:0];
    assign o_wdata.v   = r_v[STEPS];
    assign o_wdata.pos = r_pos[STEPS];

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item missing from first front stage");

    a_stall_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STEPS] && i_full) |=> (r_vld[STEPS] && $stable(o_wdata)))
        else $error("front dropped or changed a blocked item");

endmodule

// ===== rtl/svt_queue.sv =====
// Short queue between the front pipeline and the rotation back end.
`timescale 1ns / 1ps

module svt_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  svt_pkg::t_fq i_wdata,
    output logic         o_full,
    input  logic         i_rd,
    output svt_pkg::t_fq o_rdata,
    output logic         o_empty
);

    localparam int PW = svt_pkg::QPTR_W;
    localparam logic [PW:0] DEPTH = (PW + 1)'(svt_pkg::QDEPTH);

    svt_pkg::t_fq  r_mem [svt_pkg::QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr)
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_rd)
        else $error("read from empty queue");

endmodule

// ===== rtl/svt_back.sv =====
// Back pipeline: rotate the four corners, round, translate and saturate.
`timescale 1ns / 1ps

module svt_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    output logic         o_rd,
    input  svt_pkg::t_fq i_rdata,
    input  logic         i_stall,
    output logic         o_valid,
    output svt_pkg::t_xy o_corner [4]
);

    localparam int PW = 64;
    localparam int SW = PW + 1;
    localparam int RW = svt_pkg::ROT_W;
    localparam int WW = svt_pkg::WIDE_W;
    localparam logic signed [PW-1:0] RBIAS = 64'sd1 <<< (svt_pkg::ROT_FRAC - 1);

    logic               en;
    logic [1:0]         r_bv;
    logic               r_ovld;
    logic signed [31:0] w_vx [2];
    logic signed [31:0] w_vy [2];

    logic signed [PW-1:0] r_pxc [2];
    logic signed [PW-1:0] r_pxs [2];
    logic signed [PW-1:0] r_pyc [2];
    logic signed [PW-1:0] r_pys [2];
    svt_pkg::t_xy         r_pos0;
    svt_pkg::t_xy         r_pos1;
    logic signed [RW-1:0] r_rx [4];
    logic signed [RW-1:0] r_ry [4];
    svt_pkg::t_xy         r_out [4];

    assign en      = !(r_ovld && i_stall);
    assign o_rd    = en && !i_empty;
    assign o_valid = r_ovld;
    assign w_vx[0] = i_rdata.v.vx0;
    assign w_vx[1] = i_rdata.v.vx1;
    assign w_vy[0] = i_rdata.v.vy0;
    assign w_vy[1] = i_rdata.v.vy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv   <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_bv   <= {r_bv[0], o_rd};
            r_ovld <= r_bv[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // rounding bias rides on the x-side products
            for (int n = 0; n < 2; n++) begin
                r_pxc[n] <= PW'(w_vx[n]) * PW'(i_rdata.cs) + RBIAS;
                r_pxs[n] <= PW'(w_vx[n]) * PW'(i_rdata.sn) + RBIAS;
                r_pyc[n] <= PW'(w_vy[n]) * PW'(i_rdata.cs);
                r_pys[n] <= PW'(w_vy[n]) * PW'(i_rdata.sn);
            end
            r_pos0 <= i_rdata.pos;
            r_pos1 <= r_pos0;
            for (int k = 0; k < 4; k++) begin
                r_rx[k] <= RW'((SW'(r_pxc[svt_pkg::CORNER_HI_X[k]])
                               - SW'(r_pys[svt_pkg::CORNER_HI_Y[k]])) >>> svt_pkg::ROT_FRAC);
                r_ry[k] <= RW'((SW'(r_pxs[svt_pkg::CORNER_HI_X[k]])
                               + SW'(r_pyc[svt_pkg::CORNER_HI_Y[k]])) >>> svt_pkg::ROT_FRAC);
                r_out[k].x <= svt_pkg::sat32(WW'(r_rx[k]) + WW'(r_pos1.x));
                r_out[k].y <= svt_pkg::sat32(WW'(r_ry[k]) + WW'(r_pos1.y));
            end
        end
    end

    assign o_corner = r_out;

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bv[1] && en) |=> r_ovld)
        else $error("back stage item lost before output");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_bv == $past(r_bv)))
        else $error("back pipeline moved while output stalled");

endmodule

// ===== sim/sprite_quad_vertex_transform_tb.sv =====
// Self-checking testbench for the sprite quad transform with a CORDIC predictor.
`timescale 1ns / 1ps

module sprite_quad_vertex_transform_tb;

    localparam int FRAC      = 16;
    localparam int ROT_SHIFT = 30;
    localparam int PHASE_ITEMS = 450;

    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;

    localparam longint GAIN_Q30 = 652032874;
    localparam longint ATAN_TURN [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    localparam logic [3:0] HI_X = 4'b0110;
    localparam logic [3:0] HI_Y = 4'b1100;

    localparam int IDLE_PLAN  [0:3] = '{0, 58, 0, 33};
    localparam int STALL_PLAN [0:3] = '{0, 0, 58, 33};

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} t_quadrant;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic [15:0]        angle;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
    } t_sprite;

    // index 2k is corner k x, 2k+1 is corner k y
    typedef logic [7:0][31:0] t_quad;

    class t_corner_scoreboard;
        t_quad corners_due[$];
        int    mismatches;

        function new();
            mismatches = 0;
        endfunction

        function longint round_shift(input longint p, input int sh);
            return (p + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function longint clamp32(input longint v);
            if (v > longint'(Q_MAX)) return longint'(Q_MAX);
            if (v < longint'(Q_MIN)) return longint'(Q_MIN);
            return v;
        endfunction

        function t_quad predict_quad(input t_sprite s);
            logic [31:0] turn;
            t_quadrant   q;
            longint      x, y, z, dx, dy, cs, sn, vx, vy, rx, ry;
            t_quad       r;
            turn = {s.angle, 16'h0000};
            q    = t_quadrant'(turn[31:30]);
            z    = longint'(turn & 32'h3FFF_FFFF);
            x    = GAIN_Q30;
            y    = 0;
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - ATAN_TURN[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + ATAN_TURN[i];
                end
            end
            case (q)
                QUAD_I:   begin cs = x;  sn = y;  end
                QUAD_II:  begin cs = -y; sn = x;  end
                QUAD_III: begin cs = -x; sn = -y; end
                default:  begin cs = y;  sn = -x; end
            endcase
            for (int k = 0; k < 4; k++) begin
                vx = (HI_X[k] ? longint'(Q_ONE) : 0) - longint'($signed(s.pivot_x));
                vy = (HI_Y[k] ? longint'(Q_ONE) : 0) - longint'($signed(s.pivot_y));
                vx = clamp32(round_shift(vx * longint'($signed(s.scale_x)), FRAC));
                vy = clamp32(round_shift(vy * longint'($signed(s.scale_y)), FRAC));
                vx = clamp32(round_shift(vx * longint'($signed(s.size_x)), FRAC));
                vy = clamp32(round_shift(vy * longint'($signed(s.size_y)), FRAC));
                rx = round_shift(vx * cs - vy * sn, ROT_SHIFT);
                ry = round_shift(vx * sn + vy * cs, ROT_SHIFT);
                rx = clamp32(rx + longint'($signed(s.pos_x)));
                ry = clamp32(ry + longint'($signed(s.pos_y)));
                r[2*k]   = rx[31:0];
                r[2*k+1] = ry[31:0];
            end
            return r;
        endfunction

        function void note_sprite(input t_sprite s);
            corners_due.push_back(predict_quad(s));
        endfunction

        function void check_corners(input t_quad got);
            t_quad want;
            if (corners_due.size() == 0) begin
                $error("corners arrived with no sprite pending");
                mismatches++;
                return;
            end
            want = corners_due.pop_front();
            for (int k = 0; k < 8; k++) begin
                if (want[k] !== got[k]) begin
                    $error("%s expected %0d got %0d",
                           $sformatf("corner%0d_%s", k / 2, (k % 2) ? "y" : "x"),
                           $signed(want[k]), $signed(got[k]));
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return corners_due.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_scale_x = '0;
    logic signed [31:0] i_scale_y = '0;
    logic [15:0]        i_angle = '0;
    logic signed [31:0] i_pivot_x = '0;
    logic signed [31:0] i_pivot_y = '0;
    logic signed [31:0] i_size_x = '0;
    logic signed [31:0] i_size_y = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [31:0] o_corner0_x, o_corner0_y, o_corner1_x, o_corner1_y;
    logic signed [31:0] o_corner2_x, o_corner2_y, o_corner3_x, o_corner3_y;

    int idle_pct  = 0;
    int stall_pct = 0;

    t_corner_scoreboard quads = new();

    sprite_quad_vertex_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_scale_x   (i_scale_x),
        .i_scale_y   (i_scale_y),
        .i_angle     (i_angle),
        .i_pivot_x   (i_pivot_x),
        .i_pivot_y   (i_pivot_y),
        .i_size_x    (i_size_x),
        .i_size_y    (i_size_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_corner0_x (o_corner0_x),
        .o_corner0_y (o_corner0_y),
        .o_corner1_x (o_corner1_x),
        .o_corner1_y (o_corner1_y),
        .o_corner2_x (o_corner2_x),
        .o_corner2_y (o_corner2_y),
        .o_corner3_x (o_corner3_x),
        .o_corner3_y (o_corner3_y)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            quads.check_corners({o_corner3_y, o_corner3_x, o_corner2_y, o_corner2_x,
                                 o_corner1_y, o_corner1_x, o_corner0_y, o_corner0_x});
        end
    end

    function automatic t_sprite make_sprite(
        input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] sx, input logic signed [31:0] sy,
        input logic [15:0] ang,
        input logic signed [31:0] vx, input logic signed [31:0] vy,
        input logic signed [31:0] wx, input logic signed [31:0] wy
    );
        t_sprite s;
        s.pos_x = px;   s.pos_y = py;
        s.scale_x = sx; s.scale_y = sy;
        s.angle = ang;
        s.pivot_x = vx; s.pivot_y = vy;
        s.size_x = wx;  s.size_y = wy;
        return s;
    endfunction

    // mostly plausible placements, some raw words and extremes to hit saturation
    function automatic logic signed [31:0] pick_coord(input int unsigned span);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return $urandom;
        if (r < 18) begin
            case ($urandom_range(4))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return 32'sd0;
                3:       return 32'sd1;
                default: return -32'sd1;
            endcase
        end
        return int'($urandom_range(2 * span)) - int'(span);
    endfunction

    function automatic t_sprite random_sprite();
        t_sprite s;
        s.pos_x   = pick_coord(1024 << FRAC);
        s.pos_y   = pick_coord(1024 << FRAC);
        s.scale_x = pick_coord(8 << FRAC);
        s.scale_y = pick_coord(8 << FRAC);
        s.angle   = 16'($urandom_range(65535));
        s.pivot_x = pick_coord(2 << FRAC);
        s.pivot_y = pick_coord(2 << FRAC);
        s.size_x  = pick_coord(512 << FRAC);
        s.size_y  = pick_coord(512 << FRAC);
        return s;
    endfunction

    task automatic send_sprite(input t_sprite s);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid   <= 1'b1;
        i_pos_x   <= s.pos_x;
        i_pos_y   <= s.pos_y;
        i_scale_x <= s.scale_x;
        i_scale_y <= s.scale_y;
        i_angle   <= s.angle;
        i_pivot_x <= s.pivot_x;
        i_pivot_y <= s.pivot_y;
        i_size_x  <= s.size_x;
        i_size_y  <= s.size_y;
        do @(posedge i_clk); while (o_stall);
        quads.note_sprite(s);
    endtask

    initial begin
        t_sprite directed [$];
        directed.push_back(make_sprite(0, 0, 0, 0, 16'h0000, 0, 0, 0, 0));
        directed.push_back(make_sprite(0, 0, Q_ONE, Q_ONE, 16'h0000, Q_HALF, Q_HALF,
                                       Q_ONE, Q_ONE));
        // every quadrant and the wrap point of the angle
        directed.push_back(make_sprite(100 << FRAC, -50 << FRAC, 2 << FRAC, 2 << FRAC,
                                       16'h2000, 32'sh4000, 32'shC000, 16 << FRAC,
                                       16 << FRAC));
        directed.push_back(make_sprite(100 << FRAC, -50 << FRAC, 2 << FRAC, 2 << FRAC,
                                       16'h4000, 32'sh4000, 32'shC000, 16 << FRAC,
                                       16 << FRAC));
        directed.push_back(make_sprite(100 << FRAC, -50 << FRAC, 2 << FRAC, 2 << FRAC,
                                       16'h8000, 32'sh4000, 32'shC000, 16 << FRAC,
                                       16 << FRAC));
        directed.push_back(make_sprite(100 << FRAC, -50 << FRAC, 2 << FRAC, 2 << FRAC,
                                       16'hC000, 32'sh4000, 32'shC000, 16 << FRAC,
                                       16 << FRAC));
        directed.push_back(make_sprite(100 << FRAC, -50 << FRAC, 2 << FRAC, 2 << FRAC,
                                       16'hFFFF, 32'sh4000, 32'shC000, 16 << FRAC,
                                       16 << FRAC));
        // mirrored quads
        directed.push_back(make_sprite(3 << FRAC, 7 << FRAC, -32'sh0001_8000, 2 << FRAC,
                                       16'h1555, Q_HALF, Q_HALF, 32 << FRAC, 32 << FRAC));
        directed.push_back(make_sprite(-9 << FRAC, 4 << FRAC, Q_ONE, Q_ONE, 16'h6ABC,
                                       0, Q_ONE, -64 << FRAC, -8 << FRAC));
        // saturation everywhere
        directed.push_back(make_sprite(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF, Q_MAX, Q_MAX,
                                       Q_MAX, Q_MAX));
        directed.push_back(make_sprite(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'h0000, Q_MIN, Q_MIN,
                                       Q_MIN, Q_MIN));
        directed.push_back(make_sprite(0, 0, Q_ONE, Q_ONE, 16'h0000, Q_MIN, Q_MIN,
                                       Q_ONE, Q_ONE));
        directed.push_back(make_sprite(0, 0, Q_MIN, Q_MIN, 16'h3000, Q_MAX, Q_MAX,
                                       Q_ONE, Q_ONE));
        directed.push_back(make_sprite(0, 0, Q_MAX, Q_MAX, 16'h0000, 0, 0, Q_MAX, Q_MAX));
        directed.push_back(make_sprite(Q_MAX, Q_MAX, 4 << FRAC, 4 << FRAC, 16'h0000, 0, 0,
                                       100 << FRAC, 100 << FRAC));
        directed.push_back(make_sprite(Q_MIN, Q_MIN, 4 << FRAC, 4 << FRAC, 16'h0000,
                                       Q_ONE, Q_ONE, 100 << FRAC, 100 << FRAC));
        // rounding on odd low bits
        directed.push_back(make_sprite(32'sd1, -32'sd1, 32'sh0000_8001, 32'sh0000_7FFF,
                                       16'h1234, 32'sd1, -32'sd1, 32'sd3, 32'sd5));
        directed.push_back(make_sprite(-32'sd1, 32'sd1, -32'sd1, -32'sd1, 16'h0001,
                                       Q_HALF, -Q_HALF, -32'sd1, -32'sd1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) begin
            send_sprite(directed[n]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = IDLE_PLAN[phase];
            stall_pct = STALL_PLAN[phase];
            repeat (PHASE_ITEMS) send_sprite(random_sprite());
        end

        i_valid <= 1'b0;
        while (quads.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (quads.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
